FILE: sv/copy_area_rect_clip_macros.svh
// assertion macros for the checker file
`ifndef COPY_AREA_RECT_CLIP_MACROS_SVH
`define COPY_AREA_RECT_CLIP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define CARC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define CARC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/carc_pkg.sv
`timescale 1ns / 1ps

package carc_pkg;

    // coordinate and size widths of the command and result fields
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    // internal width, two bits of headroom so no step wraps
    localparam int IW         = COORD_BITS + 2;

    // exposure tiles per command and their slots, in emit order
    localparam int NUM_TILES  = 4;
    localparam int TILE_IDX_W = $clog2(NUM_TILES);
    localparam int TILE_TOP   = 0;
    localparam int TILE_LEFT  = 1;
    localparam int TILE_RIGHT = 2;
    localparam int TILE_BELOW = 3;

    // destination kind codes
    localparam logic [1:0] DK_PIXMAP = 2'd0;
    localparam logic [1:0] DK_WINDOW = 2'd1;

    typedef logic signed [IW-1:0] icoord_t;

    typedef enum logic [1:0] {
        KIND_COPY  = 2'd0,
        KIND_TILE  = 2'd1,
        KIND_NONE  = 2'd2,
        KIND_NOSRC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TGT_NONE   = 2'd0,
        TGT_PIXMAP = 2'd1,
        TGT_WINDOW = 2'd2
    } target_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] src_x;
        logic signed [COORD_BITS-1:0] src_y;
        logic signed [COORD_BITS-1:0] dst_x;
        logic signed [COORD_BITS-1:0] dst_y;
        logic [SIZE_BITS-1:0]         width;
        logic [SIZE_BITS-1:0]         height;
        logic [SIZE_BITS-1:0]         dst_width;
        logic [SIZE_BITS-1:0]         dst_height;
        logic [1:0]                   dst_kind;
        logic                         clip_source;
        logic [SIZE_BITS-1:0]         src_width;
        logic [SIZE_BITS-1:0]         src_height;
    } cmd_t;

    typedef struct packed {
        kind_t                        kind;
        target_t                      target;
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        logic signed [COORD_BITS-1:0] rect_x;
        logic signed [COORD_BITS-1:0] rect_y;
        logic [SIZE_BITS-1:0]         rect_w;
        logic [SIZE_BITS-1:0]         rect_h;
        logic                         last;
    } res_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
    } rect_t;

    // one classified command, as handed from front to back
    typedef struct packed {
        kind_t                        kind;
        target_t                      target;
        logic signed [COORD_BITS-1:0] from_x;
        logic signed [COORD_BITS-1:0] from_y;
        rect_t                        rect;
        logic [NUM_TILES-1:0]         tile_mask;
        rect_t [NUM_TILES-1:0]        tiles;
    } plan_t;

    function automatic icoord_t ext_coord(input logic [COORD_BITS-1:0] v);
        return {{(IW-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic icoord_t ext_size(input logic [SIZE_BITS-1:0] v);
        return {{(IW-SIZE_BITS){1'b0}}, v};
    endfunction

    function automatic logic signed [COORD_BITS-1:0] cut_coord(input icoord_t v);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic rect_t make_rect(input icoord_t x, input icoord_t y,
                                        input icoord_t w, input icoord_t h);
        rect_t r;
        r.x = x[COORD_BITS-1:0];
        r.y = y[COORD_BITS-1:0];
        r.w = w[SIZE_BITS-1:0];
        r.h = h[SIZE_BITS-1:0];
        return r;
    endfunction

endpackage

FILE: sv/copy_area_rect_clip.sv
`timescale 1ns / 1ps

// Area-copy clipper: each command pushed in is clipped to the destination drawable
// and, when clip_source is set, to the source drawable, and comes out as one copy
// beat followed by up to four exposure tiles (above, left, right, below), or as a
// single nothing or no-source beat; last marks a command's final beat. A front
// pipeline of three register stages takes one command per clock, while the queue
// has room, into a small command queue; the back end emits one result beat per
// clock while pop is held high, from its output register, so a command occupies
// the result side for one beat plus one per exposure tile. A command's first result
// passes the three front stages, the queue and the back end's command register
// before it is loaded into the output register.
module copy_area_rect_clip import carc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  cmd_t cmd,
    output logic empty,
    input  logic pop,
    output res_t res
);

    logic  q_push, q_full, q_pop, q_empty;
    plan_t plan_in, plan_out;

    // classify and clip
    carc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .q_push (q_push),
        .q_full (q_full),
        .plan   (plan_in)
    );

    // decoupling queue
    carc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (plan_in),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (plan_out),
        .empty   (q_empty)
    );

    // result sequencing
    carc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (plan_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

FILE: sv/carc_front.sv
`timescale 1ns / 1ps

module carc_front import carc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  cmd_t  cmd,
    output logic  q_push,
    input  logic  q_full,
    output plan_t plan
);

    typedef struct packed {
        target_t target;
        logic    none;
        logic    csrc;
        icoord_t sx;
        icoord_t sy;
        icoord_t x;
        icoord_t y;
        icoord_t w;
        icoord_t h;
        icoord_t dw;
        icoord_t dh;
        icoord_t sw;
        icoord_t sh;
    } s1_t;

    typedef struct packed {
        target_t target;
        logic    none;
        logic    csrc;
        icoord_t sx;
        icoord_t sy;
        icoord_t x;
        icoord_t y;
        icoord_t w;
        icoord_t h;
        icoord_t sw;
        icoord_t sh;
    } s2_t;

    typedef struct packed {
        target_t target;
        logic    none;
        logic    csrc;
        icoord_t sx;
        icoord_t sy;
        icoord_t x;
        icoord_t y;
        icoord_t w;
        icoord_t h;
        icoord_t dv;
        logic    below;
        logic    sx_neg;
        logic    sy_neg;
        icoord_t w1;
        icoord_t sx1;
        icoord_t sy1;
        icoord_t x1;
        icoord_t y1;
        icoord_t dhx;
    } s3_t;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;

    // stall chain back from the queue
    assign rdy3   = !v3_reg || !q_full;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign full   = !rdy1;
    assign q_push = v3_reg && !q_full;

    // stage 1: decode kind, clip at destination left and top
    always_comb
    begin
        icoord_t x, y, sx, sy, w, h;
        x  = ext_coord(cmd.dst_x);
        y  = ext_coord(cmd.dst_y);
        sx = ext_coord(cmd.src_x);
        sy = ext_coord(cmd.src_y);
        w  = ext_size(cmd.width);
        h  = ext_size(cmd.height);
        case (cmd.dst_kind)
            DK_PIXMAP:
            begin
                s1_next.target = TGT_PIXMAP;
                s1_next.none   = 1'b0;
            end
            DK_WINDOW:
            begin
                s1_next.target = TGT_WINDOW;
                s1_next.none   = 1'b0;
            end
            default:
            begin
                s1_next.target = TGT_NONE;
                s1_next.none   = 1'b1;
            end
        endcase
        s1_next.csrc = cmd.clip_source;
        s1_next.sx   = x[IW-1] ? sx - x : sx;
        s1_next.w    = x[IW-1] ? w + x : w;
        s1_next.x    = x[IW-1] ? icoord_t'(0) : x;
        s1_next.sy   = y[IW-1] ? sy - y : sy;
        s1_next.h    = y[IW-1] ? h + y : h;
        s1_next.y    = y[IW-1] ? icoord_t'(0) : y;
        s1_next.dw   = ext_size(cmd.dst_width);
        s1_next.dh   = ext_size(cmd.dst_height);
        s1_next.sw   = ext_size(cmd.src_width);
        s1_next.sh   = ext_size(cmd.src_height);
    end

    // stage 2: clip at destination right and bottom
    always_comb
    begin
        icoord_t wlim, hlim;
        wlim = s1_reg.dw - s1_reg.x;
        hlim = s1_reg.dh - s1_reg.y;
        s2_next.target = s1_reg.target;
        s2_next.none   = s1_reg.none;
        s2_next.csrc   = s1_reg.csrc;
        s2_next.sx     = s1_reg.sx;
        s2_next.sy     = s1_reg.sy;
        s2_next.x      = s1_reg.x;
        s2_next.y      = s1_reg.y;
        s2_next.w      = (s1_reg.w > wlim) ? wlim : s1_reg.w;
        s2_next.h      = (s1_reg.h > hlim) ? hlim : s1_reg.h;
        s2_next.sw     = s1_reg.sw;
        s2_next.sh     = s1_reg.sh;
    end

    // stage 3: empty check, source bounds in both axes side by side
    always_comb
    begin
        logic sxn, syn;
        sxn = s2_reg.sx[IW-1];
        syn = s2_reg.sy[IW-1];
        s3_next.target = s2_reg.target;
        s3_next.none   = s2_reg.none || (s2_reg.w <= 0) || (s2_reg.h <= 0);
        s3_next.csrc   = s2_reg.csrc;
        s3_next.sx     = s2_reg.sx;
        s3_next.sy     = s2_reg.sy;
        s3_next.x      = s2_reg.x;
        s3_next.y      = s2_reg.y;
        s3_next.w      = s2_reg.w;
        s3_next.h      = s2_reg.h;
        s3_next.dv     = s2_reg.sh - s2_reg.sy;
        s3_next.below  = s2_reg.h > (s2_reg.sh - s2_reg.sy);
        s3_next.sx_neg = sxn;
        s3_next.sy_neg = syn;
        s3_next.w1     = sxn ? s2_reg.w + s2_reg.sx : s2_reg.w;
        s3_next.sx1    = sxn ? icoord_t'(0) : s2_reg.sx;
        s3_next.sy1    = syn ? icoord_t'(0) : s2_reg.sy;
        s3_next.x1     = sxn ? s2_reg.x - s2_reg.sx : s2_reg.x;
        s3_next.y1     = syn ? s2_reg.y - s2_reg.sy : s2_reg.y;
        s3_next.dhx    = sxn ? s2_reg.sw : s2_reg.sw - s2_reg.sx;
    end

    // final step into the queue: remaining sizes, tiles and the verdict
    always_comb
    begin
        icoord_t hmin, hf, wf;
        logic    right, nosrc;
        hmin  = s3_reg.below ? s3_reg.dv : s3_reg.h;
        hf    = s3_reg.sy_neg ? hmin + s3_reg.sy : hmin;
        right = s3_reg.w1 > s3_reg.dhx;
        wf    = right ? s3_reg.dhx : s3_reg.w1;
        nosrc = (hf <= 0) || (wf <= 0);

        plan.tiles[TILE_TOP]   = make_rect(s3_reg.x, s3_reg.y, s3_reg.w, -s3_reg.sy);
        plan.tiles[TILE_LEFT]  = make_rect(s3_reg.x, s3_reg.y1, -s3_reg.sx, hf);
        plan.tiles[TILE_RIGHT] = make_rect(s3_reg.x1 + s3_reg.dhx, s3_reg.y1,
                                           s3_reg.w1 - s3_reg.dhx, hf);
        plan.tiles[TILE_BELOW] = make_rect(s3_reg.x, s3_reg.y + s3_reg.dv, s3_reg.w,
                                           s3_reg.h - s3_reg.dv);
        plan.tile_mask = '0;
        plan.target    = s3_reg.target;
        plan.from_x    = '0;
        plan.from_y    = '0;
        plan.rect      = make_rect(s3_reg.x, s3_reg.y, s3_reg.w, s3_reg.h);
        if (s3_reg.none)
        begin
            plan.kind   = KIND_NONE;
            plan.target = TGT_NONE;
            plan.rect   = '0;
        end
        else if (!s3_reg.csrc)
        begin
            plan.kind   = KIND_COPY;
            plan.from_x = cut_coord(s3_reg.sx);
            plan.from_y = cut_coord(s3_reg.sy);
        end
        else if (nosrc)
        begin
            plan.kind = KIND_NOSRC;
        end
        else
        begin
            plan.kind                  = KIND_COPY;
            plan.from_x                = cut_coord(s3_reg.sx1);
            plan.from_y                = cut_coord(s3_reg.sy1);
            plan.rect                  = make_rect(s3_reg.x1, s3_reg.y1, wf, hf);
            plan.tile_mask[TILE_TOP]   = s3_reg.sy_neg;
            plan.tile_mask[TILE_LEFT]  = s3_reg.sx_neg;
            plan.tile_mask[TILE_RIGHT] = right;
            plan.tile_mask[TILE_BELOW] = s3_reg.below;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= push;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (rdy1)
            s1_reg <= s1_next;
        if (rdy2)
            s2_reg <= s2_next;
        if (rdy3)
            s3_reg <= s3_next;
    end

endmodule

FILE: sv/carc_queue.sv
`timescale 1ns / 1ps

module carc_queue import carc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  plan_t wr_data,
    output logic  full,
    input  logic  rd,
    output plan_t rd_data,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plan_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/carc_back.sv
`timescale 1ns / 1ps

module carc_back import carc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  plan_t q_data,
    input  logic  q_empty,
    output logic  q_pop,
    output logic  empty,
    input  logic  pop,
    output res_t  res
);

    logic                  cur_valid_reg, cur_valid_next;
    logic                  pend_first_reg, pend_first_next;
    logic [NUM_TILES-1:0]  pend_tiles_reg, pend_tiles_next;
    plan_t                 plan_reg;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg;
    logic                  load_ok, emit, emit_last;
    logic [TILE_IDX_W-1:0] sel;
    logic [NUM_TILES-1:0]  rest_tiles;
    res_t                  emit_res;

    assign empty   = !out_valid_reg;
    assign res     = out_reg;
    assign load_ok = !out_valid_reg || pop;
    assign emit    = cur_valid_reg && load_ok;

    // pick the next result of the current command
    always_comb
    begin
        sel = '0;
        for (int i = NUM_TILES - 1; i >= 0; i--)
        begin
            if (pend_tiles_reg[i])
                sel = TILE_IDX_W'(i);
        end
        if (pend_first_reg)
        begin
            rest_tiles      = pend_tiles_reg;
            emit_res.kind   = plan_reg.kind;
            emit_res.from_x = plan_reg.from_x;
            emit_res.from_y = plan_reg.from_y;
            emit_res.rect_x = plan_reg.rect.x;
            emit_res.rect_y = plan_reg.rect.y;
            emit_res.rect_w = plan_reg.rect.w;
            emit_res.rect_h = plan_reg.rect.h;
        end
        else
        begin
            rest_tiles      = pend_tiles_reg & ~(NUM_TILES'(1) << sel);
            emit_res.kind   = KIND_TILE;
            emit_res.from_x = '0;
            emit_res.from_y = '0;
            emit_res.rect_x = plan_reg.tiles[sel].x;
            emit_res.rect_y = plan_reg.tiles[sel].y;
            emit_res.rect_w = plan_reg.tiles[sel].w;
            emit_res.rect_h = plan_reg.tiles[sel].h;
        end
        emit_last       = (rest_tiles == '0);
        emit_res.target = plan_reg.target;
        emit_res.last   = emit_last;
    end

    // take the next command when none is current or as the current one finishes
    assign q_pop = (!cur_valid_reg || (emit && emit_last)) && !q_empty;

    always_comb
    begin
        cur_valid_next  = cur_valid_reg;
        pend_first_next = pend_first_reg;
        pend_tiles_next = pend_tiles_reg;
        if (q_pop)
        begin
            cur_valid_next  = 1'b1;
            pend_first_next = 1'b1;
            pend_tiles_next = q_data.tile_mask;
        end
        else if (emit && emit_last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            pend_first_next = 1'b0;
            pend_tiles_next = rest_tiles;
        end
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            pend_first_reg <= 1'b0;
            pend_tiles_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            pend_first_reg <= pend_first_next;
            pend_tiles_reg <= pend_tiles_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            plan_reg <= q_data;
        if (emit)
            out_reg <= emit_res;
    end

endmodule

FILE: sv/carc_checker.sv
`timescale 1ns / 1ps
`include "copy_area_rect_clip_macros.svh"

module carc_checker import carc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input cmd_t cmd,
    input logic empty,
    input logic pop,
    input res_t res
);

    // a waiting result beat holds until taken
    `CARC_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(res), "result changed while stalled")

    // a nothing beat stands alone with no target
    `CARC_ASSERT_IMP(a_none_alone, !empty && res.kind == KIND_NONE, res.last && res.target == TGT_NONE, "nothing beat not last or targeted")

    // a non-final beat is followed at once by a tile
    `CARC_ASSERT_IMP(a_tile_follows, $past(!empty && pop && !res.last), !empty && res.kind == KIND_TILE, "no tile after non-final beat")

    // tiles carry no source origin
    `CARC_ASSERT_IMP(a_tile_from, !empty && res.kind == KIND_TILE, res.from_x == 0 && res.from_y == 0, "tile with source origin")

endmodule

bind copy_area_rect_clip carc_checker u_carc_checker (.*);

FILE: test/copy_area_rect_clip_test.sv
`timescale 1ns / 1ps

module copy_area_rect_clip_test;
    import carc_pkg::*;

    // destination kinds that give a 'nothing' beat
    localparam logic [1:0] DK_HIDDEN  = 2'd2;
    localparam logic [1:0] DK_INVALID = 2'd3;

    localparam int RANDOM_CMDS = 500;
    localparam int TAIL_CMDS   = 50;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    cmd_t cmd = '0;
    logic full;
    logic empty;
    res_t res;

    cmd_t pending_cmds[$];
    res_t expected_beats[$];
    int cmds_total = 0;
    int cmds_accepted = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    bit cmd_taken = 1'b0;
    bit quiet_tail = 1'b0;
    bit long_hold_req = 1'b0;

    copy_area_rect_clip dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .cmd   (cmd),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // build one result beat, fields cut to the port widths
    function automatic res_t make_beat(input kind_t k, input target_t t,
                                       input int fx, input int fy, input int rx,
                                       input int ry, input int rw, input int rh,
                                       input bit lst);
        res_t b;
        b.kind   = k;
        b.target = t;
        b.from_x = fx[15:0];
        b.from_y = fy[15:0];
        b.rect_x = rx[15:0];
        b.rect_y = ry[15:0];
        b.rect_w = rw[14:0];
        b.rect_h = rh[14:0];
        b.last   = lst;
        return b;
    endfunction

    // clip one copy command and queue the beats it should produce
    function automatic void clip_copy_area(input cmd_t c);
        int sx, sy, x, y, w, h, dw, dh, sw, sh, d;
        int kx, ky, kw, kh, bx, by, bw, bh;
        int tx[NUM_TILES];
        int ty[NUM_TILES];
        int tw[NUM_TILES];
        int th[NUM_TILES];
        int nt;
        bit below;
        bit no_src;
        target_t tgt;
        sx = $signed(c.src_x);
        sy = $signed(c.src_y);
        x  = $signed(c.dst_x);
        y  = $signed(c.dst_y);
        w  = c.width;
        h  = c.height;
        dw = c.dst_width;
        dh = c.dst_height;
        sw = c.src_width;
        sh = c.src_height;
        nt = 0;
        below = 1'b0;
        no_src = 1'b0;
        bx = 0;
        by = 0;
        bw = 0;
        bh = 0;

        if (c.dst_kind == DK_PIXMAP)
            tgt = TGT_PIXMAP;
        else if (c.dst_kind == DK_WINDOW)
            tgt = TGT_WINDOW;
        else
        begin
            expected_beats.push_back(make_beat(KIND_NONE, TGT_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end

        // destination edges, left and top also move the source
        if (x < 0)
        begin
            sx -= x;
            w += x;
            x = 0;
        end
        if (x + w > dw)
            w = dw - x;
        if (y < 0)
        begin
            sy -= y;
            h += y;
            y = 0;
        end
        if (y + h > dh)
            h = dh - y;
        if (w <= 0 || h <= 0)
        begin
            expected_beats.push_back(make_beat(KIND_NONE, TGT_NONE, 0, 0, 0, 0, 0, 0, 1'b1));
            return;
        end
        if (!c.clip_source)
        begin
            expected_beats.push_back(make_beat(KIND_COPY, tgt, sx, sy, x, y, w, h, 1'b1));
            return;
        end

        // source bounds: strips below, above, left, right
        kx = x;
        ky = y;
        kw = w;
        kh = h;
        d = sh - sy;
        if (h > d)
        begin
            below = 1'b1;
            bx = x;
            by = y + d;
            bw = w;
            bh = h - d;
            h = d;
            if (h <= 0)
                no_src = 1'b1;
        end
        if (!no_src && sy < 0)
        begin
            h += sy;
            if (h <= 0)
                no_src = 1'b1;
            else
            begin
                tx[nt] = x;
                ty[nt] = y;
                tw[nt] = w;
                th[nt] = -sy;
                nt++;
                y -= sy;
                sy = 0;
            end
        end
        if (!no_src && sx < 0)
        begin
            w += sx;
            if (w <= 0)
                no_src = 1'b1;
            else
            begin
                tx[nt] = x;
                ty[nt] = y;
                tw[nt] = -sx;
                th[nt] = h;
                nt++;
                x -= sx;
                sx = 0;
            end
        end
        if (!no_src)
        begin
            d = sw - sx;
            if (w > d)
            begin
                if (d <= 0)
                    no_src = 1'b1;
                else
                begin
                    tx[nt] = x + d;
                    ty[nt] = y;
                    tw[nt] = w - d;
                    th[nt] = h;
                    nt++;
                    w = d;
                end
            end
        end
        if (no_src)
        begin
            expected_beats.push_back(make_beat(KIND_NOSRC, tgt, 0, 0, kx, ky, kw, kh, 1'b1));
            return;
        end
        if (below)
        begin
            tx[nt] = bx;
            ty[nt] = by;
            tw[nt] = bw;
            th[nt] = bh;
            nt++;
        end

        expected_beats.push_back(make_beat(KIND_COPY, tgt, sx, sy, x, y, w, h, nt == 0));
        for (int i = 0; i < nt; i++)
            expected_beats.push_back(make_beat(KIND_TILE, tgt, 0, 0, tx[i], ty[i], tw[i], th[i],
                                               i == nt - 1));
    endfunction

    function automatic cmd_t make_cmd(input int sx, input int sy, input int dx, input int dy,
                                      input int w, input int h, input int dw, input int dh,
                                      input logic [1:0] dk, input bit cs,
                                      input int sw, input int sh);
        cmd_t c;
        c.src_x       = sx[15:0];
        c.src_y       = sy[15:0];
        c.dst_x       = dx[15:0];
        c.dst_y       = dy[15:0];
        c.width       = w[14:0];
        c.height      = h[14:0];
        c.dst_width   = dw[14:0];
        c.dst_height  = dh[14:0];
        c.dst_kind    = dk;
        c.clip_source = cs;
        c.src_width   = sw[14:0];
        c.src_height  = sh[14:0];
        return c;
    endfunction

    function automatic void queue_cmd(input cmd_t c);
        pending_cmds.push_back(c);
        cmds_total++;
    endfunction

    // mostly small drawables so every clipping path is hit, some raw noise
    function automatic cmd_t random_cmd();
        logic [159:0] raw;
        logic [1:0] dk;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            return raw[$bits(cmd_t)-1:0];
        end
        if ($urandom_range(0, 9) == 0)
            dk = 2'($urandom_range(DK_HIDDEN, DK_INVALID));
        else
            dk = 2'($urandom_range(DK_PIXMAP, DK_WINDOW));
        return make_cmd(int'($urandom_range(0, 180)) - 40, int'($urandom_range(0, 180)) - 40,
                        int'($urandom_range(0, 180)) - 40, int'($urandom_range(0, 180)) - 40,
                        $urandom_range(mode == 1 ? 0 : 1, 160),
                        $urandom_range(mode == 1 ? 0 : 1, 160),
                        $urandom_range(mode == 2 ? 0 : 1, 140),
                        $urandom_range(mode == 2 ? 0 : 1, 140),
                        dk, $urandom_range(0, 3) != 0,
                        $urandom_range(mode == 3 ? 0 : 1, 140),
                        $urandom_range(mode == 3 ? 0 : 1, 140));
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmds_accepted != cmds_total || expected_beats.size() != 0);
    endtask

    // command beats taken by the block feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            clip_copy_area(cmd);
            cmds_accepted++;
            cmd_taken <= 1'b1;
        end
        else
            cmd_taken <= 1'b0;
    end

    // command driver with random idle bursts
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (push && !cmd_taken)
            ;
        else if (send_gap > 0)
        begin
            push <= 1'b0;
            send_gap--;
        end
        else if (pending_cmds.size() > 0)
        begin
            cmd <= pending_cmds.pop_front();
            push <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 19);
        end
        else
            push <= 1'b0;
    end

    // result side ready, with random stalls and one long hold
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (recv_stall > 0)
        begin
            pop <= 1'b0;
            recv_stall--;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            recv_stall = LONG_HOLD;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 7) == 0)
                recv_stall = $urandom_range(1, 19);
        end
    end

    // compare each result beat with the oldest expected one
    always @(posedge clk)
    begin : check_beats
        res_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: kind %0d", res.kind);
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("kind", want.kind, res.kind);
                check_field("target", want.target, res.target);
                check_field("from_x", want.from_x, res.from_x);
                check_field("from_y", want.from_y, res.from_y);
                check_field("rect_x", want.rect_x, res.rect_x);
                check_field("rect_y", want.rect_y, res.rect_y);
                check_field("rect_w", want.rect_w, res.rect_w);
                check_field("rect_h", want.rect_h, res.rect_h);
                check_field("last", want.last, res.last);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hidden and unknown destination kinds
        queue_cmd(make_cmd(0, 0, 0, 0, 10, 10, 100, 100, DK_HIDDEN, 1, 100, 100));
        queue_cmd(make_cmd(0, 0, 0, 0, 10, 10, 100, 100, DK_INVALID, 0, 100, 100));
        // plain copies, no clipping needed
        queue_cmd(make_cmd(5, 6, 10, 20, 30, 40, 100, 100, DK_PIXMAP, 0, 50, 50));
        queue_cmd(make_cmd(5, 6, 10, 20, 30, 40, 100, 100, DK_WINDOW, 1, 100, 100));
        // destination edges, left/top shift the source
        queue_cmd(make_cmd(10, 10, -5, -7, 30, 30, 100, 100, DK_PIXMAP, 0, 100, 100));
        queue_cmd(make_cmd(0, 0, 90, 95, 30, 30, 100, 100, DK_WINDOW, 0, 100, 100));
        // clipped away at the destination
        queue_cmd(make_cmd(0, 0, 200, 0, 30, 30, 100, 100, DK_PIXMAP, 1, 100, 100));
        queue_cmd(make_cmd(0, 0, -50, 0, 30, 30, 100, 100, DK_WINDOW, 0, 100, 100));
        // zero sizes
        queue_cmd(make_cmd(0, 0, 0, 0, 0, 10, 100, 100, DK_PIXMAP, 1, 100, 100));
        queue_cmd(make_cmd(0, 0, 0, 0, 10, 10, 100, 0, DK_WINDOW, 0, 100, 100));
        queue_cmd(make_cmd(0, 0, 0, 0, 10, 10, 100, 100, DK_PIXMAP, 1, 0, 100));
        // all four exposure strips
        queue_cmd(make_cmd(-5, -4, 10, 10, 50, 40, 100, 100, DK_WINDOW, 1, 20, 20));
        // each strip alone: above, left, right, below
        queue_cmd(make_cmd(0, -5, 0, 0, 10, 10, 100, 100, DK_PIXMAP, 1, 50, 50));
        queue_cmd(make_cmd(-5, 0, 0, 0, 10, 10, 100, 100, DK_WINDOW, 1, 50, 50));
        queue_cmd(make_cmd(45, 0, 0, 0, 10, 10, 100, 100, DK_PIXMAP, 1, 50, 50));
        queue_cmd(make_cmd(0, 45, 0, 0, 10, 10, 100, 100, DK_WINDOW, 1, 50, 50));
        // no source overlap from each side
        queue_cmd(make_cmd(0, 60, 3, 4, 10, 10, 100, 100, DK_PIXMAP, 1, 50, 50));
        queue_cmd(make_cmd(0, -20, 3, 4, 10, 10, 100, 100, DK_WINDOW, 1, 50, 50));
        queue_cmd(make_cmd(-20, 0, 3, 4, 10, 10, 100, 100, DK_PIXMAP, 1, 50, 50));
        queue_cmd(make_cmd(60, 0, 3, 4, 10, 10, 100, 100, DK_WINDOW, 1, 50, 50));
        // source origin wraps when source clipping is off
        queue_cmd(make_cmd(32767, 32767, -100, -100, 32767, 32767, 32767, 32767,
                           DK_PIXMAP, 0, 32767, 32767));
        // field extremes
        queue_cmd(make_cmd(0, 0, 0, 0, 32767, 32767, 32767, 32767, DK_WINDOW, 1, 32767, 32767));
        queue_cmd(make_cmd(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                           DK_WINDOW, 1, 32767, 32767));
        queue_cmd(make_cmd(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                           DK_PIXMAP, 1, 32767, 32767));
        queue_cmd(make_cmd(-3, -3, -10, -10, 50, 50, 30, 30, DK_PIXMAP, 1, 20, 20));

        // sender holds until every directed result is back
        wait_drained();

        for (int i = 0; i < RANDOM_CMDS; i++)
            queue_cmd(random_cmd());
        long_hold_req = 1'b1;

        while (cmds_accepted < cmds_total - TAIL_CMDS)
            @(negedge clk);
        quiet_tail = 1'b1;

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/carc_pkg.sv
sv/carc_front.sv
sv/carc_queue.sv
sv/carc_back.sv
sv/copy_area_rect_clip.sv
sv/carc_checker.sv
test/copy_area_rect_clip_test.sv
